[hdl/sgdbl_pkg.sv]
// shared types, constants and helpers of the scatter-gather descriptor table loader
`default_nettype none

package sgdbl_pkg;

  localparam int unsigned MAX_SLOTS_DEF    = 512;
  localparam int unsigned IMM_PAYLOAD_BITS = 28;

  localparam int unsigned QDEPTH_W  = 10;
  localparam int unsigned CHUNK_W   = 21;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned RIDX_W    = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 21;

  localparam int unsigned S_TDATA_W = 160;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 96;
  localparam int unsigned M_TUSER_W = 3;

  // shared divider: dividend, divisor and quotient bits retired per cycle
  localparam int unsigned DIV_W      = 32;
  localparam int unsigned DVSR_W     = 21;
  localparam int unsigned DIV_RADIX  = 4;
  localparam int unsigned DIV_STEPS  = DIV_W / DIV_RADIX;
  localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS);

  localparam logic [QDEPTH_W-1:0] QDEPTH_RST = 10'd512;
  localparam logic [CHUNK_W-1:0]  CHUNK_RST  = 21'd65536;

  typedef enum logic [2:0] {
    STS_ACCEPTED   = 3'd0,
    STS_VALID      = 3'd1,
    STS_BAD_COUNT  = 3'd2,
    STS_IMM_SMALL  = 3'd3,
    STS_BAD_LEN    = 3'd4,
    STS_NOT_MAPPED = 3'd5,
    STS_BAD_TOTAL  = 3'd6,
    STS_IGNORED    = 3'd7
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUEUE_DEPTH = 1'b0,
    REG_CHUNK_SIZE  = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CNTDIV,
    S_IMM,
    S_BODY,
    S_LENDIV,
    S_FILL,
    S_TAIL,
    S_FINAL,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [DVSR_W-1:0] rem;
  } div_rsp_t;

  // number of significant bits of a 32-bit value
  function automatic logic [5:0] bit_len(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = 6'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[hdl/sg_descriptor_buffer_table_loader.sv]
// top level: descriptor checks, chunk table fill and slot read-back
// flow: a slot read passes the read registers, the staged result and the output register;
//   a descriptor runs one divide on the 4-bit-per-cycle divider, the opening one of a
//   message a count divide first, and then writes its slots through the single table write port
// throughput: one item at a time; the next input is taken once the result is loaded into the output register
// reset: control state, message state, output valid and configuration registers clear at once; the slot table
//   gets no clearing pass and is undefined until written
`default_nettype none

module sg_descriptor_buffer_table_loader #(
  parameter int unsigned MAX_SLOTS = sgdbl_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [sgdbl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sgdbl_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sg_count, desc_addr, desc_key, desc_len, read_index, zero pad
  input  wire logic [sgdbl_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // req_type, first
  input  wire logic [sgdbl_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // entry_addr, entry_key
  output logic [sgdbl_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // status
  output logic [sgdbl_pkg::M_TUSER_W-1:0]        m_axis_tuser,
  // message_done
  output logic                                   m_axis_tlast
);
  import sgdbl_pkg::*;

  localparam int unsigned DW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = (DW > QDEPTH_W) ? DW : QDEPTH_W;

  // input fields
  logic [COUNT_W-1:0] in_count;
  logic [ADDR_W-1:0]  in_addr;
  logic [KEY_W-1:0]   in_key;
  logic [LEN_W-1:0]   in_len;
  logic [RIDX_W-1:0]  in_ridx;
  logic               in_req_type, in_first, in_xfer;

  assign in_count    = s_axis_tdata[15:0];
  assign in_addr     = s_axis_tdata[79:16];
  assign in_key      = s_axis_tdata[111:80];
  assign in_len      = s_axis_tdata[143:112];
  assign in_ridx     = s_axis_tdata[152:144];
  assign in_req_type = s_axis_tuser[0];
  assign in_first    = s_axis_tuser[1];
  assign in_xfer     = s_axis_tvalid && s_axis_tready;

  // configuration
  logic [QDEPTH_W-1:0] qdepth_q;
  logic [CHUNK_W-1:0]  chunk_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qdepth_q <= QDEPTH_RST;
      chunk_q  <= CHUNK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_QUEUE_DEPTH: qdepth_q <= cfg_data_i[QDEPTH_W-1:0];
        REG_CHUNK_SIZE:  chunk_q  <= cfg_data_i[CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] depth;
  always_comb begin
    logic [CW-1:0] qd, mx;
    qd    = CW'(qdepth_q);
    mx    = CW'(MAX_SLOTS);
    depth = DW'((qd > mx) ? mx : qd);
  end

  // message state
  state_e            state_q, state_d;
  logic              open_q;
  logic [DW-1:0]     fill_q;
  logic [COUNT_W-1:0] desc_q;
  logic [COUNT_W-1:0] exp_q;
  logic [LEN_W-1:0]  total_q;

  // item latches and working registers
  logic [COUNT_W-1:0] cnt_q;
  logic [ADDR_W-1:0]  addr_q, cur_addr_q;
  logic [KEY_W-1:0]   key_q;
  logic [LEN_W-1:0]   len_q;
  logic [DW-1:0]      slots_q;
  logic [31:0]        prod_q;

  // staged result and output register
  status_e            res_sts_q, fin_sts;
  logic               res_done_q, fin_done, fin, fin_rd;
  logic [ADDR_W-1:0]  res_addr_q, rd_addr_q;
  logic [KEY_W-1:0]   res_key_q, rd_key_q;
  logic               m_valid_q, out_load;

  // slot table
  logic [ADDR_W-1:0] addr_mem [MAX_SLOTS];
  logic [KEY_W-1:0]  key_mem  [MAX_SLOTS];
  logic              mem_we;

  div_req_t div_req;
  div_rsp_t div_rsp;

  sgdbl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic          idx_bad, imm_bad, body_bad_len;
  logic [DW-1:0] room, slots_new;

  assign idx_bad = (32'(in_ridx) >= 32'(MAX_SLOTS));
  assign room    = depth - fill_q;

  always_comb begin
    logic [6:0]  sum;
    logic [31:0] cm1;
    cm1     = (chunk_q == '0) ? '1 : 32'(chunk_q - 1'b1);
    sum     = 7'(bit_len(32'(cnt_q - 1'b1))) + 7'(bit_len(cm1));
    imm_bad = (32'(sum) > 32'(IMM_PAYLOAD_BITS));
  end

  assign body_bad_len = (len_q == '0) || (chunk_q == '0);
  assign slots_new    = (div_rsp.quot > 32'(room)) ? room : DW'(div_rsp.quot);

  always_comb begin
    state_d          = state_q;
    fin              = 1'b0;
    fin_sts          = STS_ACCEPTED;
    fin_done         = 1'b0;
    fin_rd           = 1'b0;
    mem_we           = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = 32'(depth);
    div_req.divisor  = DVSR_W'(in_count);
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_req_type) begin
            if (idx_bad) begin
              fin     = 1'b1;
              fin_sts = STS_IGNORED;
              state_d = S_RESULT;
            end else begin
              state_d = S_READ;
            end
          end else if (in_first) begin
            if (in_count == '0 || depth == '0) begin
              fin      = 1'b1;
              fin_sts  = STS_BAD_COUNT;
              fin_done = 1'b1;
              state_d  = S_RESULT;
            end else begin
              div_req.start = 1'b1;
              state_d       = S_CNTDIV;
            end
          end else if (!open_q) begin
            fin     = 1'b1;
            fin_sts = STS_IGNORED;
            state_d = S_RESULT;
          end else begin
            state_d = S_BODY;
          end
        end
      end
      S_READ: begin
        fin     = 1'b1;
        fin_rd  = 1'b1;
        state_d = S_RESULT;
      end
      S_CNTDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != '0) begin
            fin      = 1'b1;
            fin_sts  = STS_BAD_COUNT;
            fin_done = 1'b1;
            state_d  = S_RESULT;
          end else begin
            state_d = S_IMM;
          end
        end
      end
      S_IMM: begin
        if (imm_bad) begin
          fin      = 1'b1;
          fin_sts  = STS_IMM_SMALL;
          fin_done = 1'b1;
          state_d  = S_RESULT;
        end else begin
          state_d = S_BODY;
        end
      end
      S_BODY: begin
        div_req.dividend = len_q;
        div_req.divisor  = chunk_q;
        if (fill_q >= depth) begin
          fin      = 1'b1;
          fin_sts  = STS_NOT_MAPPED;
          fin_done = 1'b1;
          state_d  = S_RESULT;
        end else if (body_bad_len) begin
          fin      = 1'b1;
          fin_sts  = STS_BAD_LEN;
          fin_done = 1'b1;
          state_d  = S_RESULT;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_LENDIV;
        end
      end
      S_LENDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != '0) begin
            fin      = 1'b1;
            fin_sts  = STS_BAD_LEN;
            fin_done = 1'b1;
            state_d  = S_RESULT;
          end else begin
            state_d = S_FILL;
          end
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        if (slots_q == DW'(1)) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_FINAL;
      end
      S_FINAL: begin
        fin = 1'b1;
        if (desc_q != exp_q) begin
          fin_sts = STS_ACCEPTED;
        end else if (fill_q != depth) begin
          fin_sts  = STS_NOT_MAPPED;
          fin_done = 1'b1;
        end else if (total_q != prod_q) begin
          fin_sts  = STS_BAD_TOTAL;
          fin_done = 1'b1;
        end else begin
          fin_sts  = STS_VALID;
          fin_done = 1'b1;
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      fill_q  <= '0;
      desc_q  <= '0;
      exp_q   <= '0;
      total_q <= '0;
    end else begin
      if (state_q == S_IDLE && in_xfer && !in_req_type && in_first) begin
        open_q  <= 1'b1;
        fill_q  <= '0;
        desc_q  <= '0;
        total_q <= '0;
        exp_q   <= in_count;
      end
      if (state_q == S_BODY && fill_q < depth) begin
        total_q <= total_q + len_q;
      end
      if (mem_we) begin
        fill_q <= fill_q + 1'b1;
      end
      if (state_q == S_TAIL) begin
        desc_q <= desc_q + 1'b1;
      end
      if (fin && fin_done) begin
        open_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cnt_q  <= in_count;
      addr_q <= in_addr;
      key_q  <= in_key;
      len_q  <= in_len;
    end
    if (state_q == S_LENDIV && div_rsp.done) begin
      slots_q    <= slots_new;
      cur_addr_q <= addr_q;
    end else if (mem_we) begin
      slots_q    <= slots_q - 1'b1;
      cur_addr_q <= cur_addr_q + ADDR_W'(chunk_q);
    end
    if (state_q == S_TAIL) begin
      prod_q <= 32'(32'(chunk_q) * 32'(depth));
    end
    if (fin) begin
      res_sts_q  <= fin_sts;
      res_done_q <= fin_done;
      res_addr_q <= fin_rd ? rd_addr_q : '0;
      res_key_q  <= fin_rd ? rd_key_q : '0;
    end
  end

  // table write during fill, registered read on a read request transfer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      addr_mem[fill_q[AW-1:0]] <= cur_addr_q;
      key_mem[fill_q[AW-1:0]]  <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_req_type && !idx_bad) begin
      rd_addr_q <= addr_mem[AW'(in_ridx)];
      rd_key_q  <= key_mem[AW'(in_ridx)];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= {res_key_q, res_addr_q};
      m_axis_tuser <= res_sts_q;
      m_axis_tlast <= res_done_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign s_axis_tready = (state_q == S_IDLE);

  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_RESULT))
    else $error("output valid rose without a staged result");

  a_close_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(open_q) |-> res_done_q)
    else $error("message closed without a message-done result");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_CNTDIV || state_q == S_LENDIV))
    else $error("divider finished while nobody waited for it");

endmodule

`default_nettype wire

[hdl/sgdbl_div.sv]
// radix-16 restoring divider shared by the count and length checks
`default_nettype none

module sgdbl_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  sgdbl_pkg::div_req_t    req_i,
  output sgdbl_pkg::div_rsp_t    rsp_o
);
  import sgdbl_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_STEP_W-1:0] step_q;
  logic [DIV_W-1:0]      quot_q, quot_d;
  logic [DVSR_W:0]       rem_q, rem_d;
  logic [DVSR_W-1:0]     dvsr_q;

  always_comb begin
    logic [DVSR_W:0]  r;
    logic [DIV_W-1:0] q;
    r = rem_q;
    q = quot_q;
    for (int i = 0; i < int'(DIV_RADIX); i++) begin
      r = {r[DVSR_W-1:0], q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, dvsr_q}) begin
        r    = r - {1'b0, dvsr_q};
        q[0] = 1'b1;
      end
    end
    rem_d  = r;
    quot_d = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == DIV_STEP_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      dvsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[DVSR_W-1:0];

endmodule

`default_nettype wire

[dv/tb_top.sv]
// self-checking testbench of the scatter-gather descriptor table loader
`timescale 1ns / 100ps

module tb_top;
  import sgdbl_pkg::*;

  localparam int unsigned SLOTS       = MAX_SLOTS_DEF;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned RX_HOLD     = 400;
  localparam int unsigned SETTLE      = 600;

  typedef struct packed {
    logic              req_type;
    logic              first_desc;
    logic [15:0]       count;
    logic [63:0]       addr;
    logic [31:0]       key;
    logic [31:0]       len;
    logic [RIDX_W-1:0] rd_idx;
  } sg_item_t;

  typedef struct packed {
    status_e     status;
    logic        done;
    logic [63:0] addr;
    logic [31:0] key;
  } sg_result_t;

  typedef enum {
    FLAW_NONE, FLAW_COUNT, FLAW_ZERO_LEN, FLAW_ODD_LEN,
    FLAW_LONG, FLAW_SHORT, FLAW_CUT, FLAW_OVERFILL
  } msg_flaw_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;

  // table model
  logic [QDEPTH_W-1:0] cfg_depth;
  logic [CHUNK_W-1:0]  cfg_chunk;
  logic [63:0]         tbl_addr [SLOTS];
  logic [31:0]         tbl_key  [SLOTS];
  bit                  tbl_written [SLOTS];
  int unsigned         written_slots [$];
  int unsigned         fill_ptr;
  logic [15:0]         desc_seen;
  logic [15:0]         desc_expected;
  logic [31:0]         len_sum;
  bit                  msg_open;

  sg_result_t  result_q [$];
  int unsigned err_cnt;
  int unsigned items_done;
  int unsigned stall_cycles;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned rx_hold_left;
  bit          rx_hold_req;

  sg_descriptor_buffer_table_loader DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int unsigned sig_bits(input logic [31:0] v);
    return $clog2({1'b0, v} + 33'd1);
  endfunction

  function automatic sg_result_t close_msg(input status_e s);
    sg_result_t r;
    r = '0;
    r.status = s;
    r.done = 1'b1;
    msg_open = 1'b0;
    return r;
  endfunction

  // expected result of one item; updates the table model
  function automatic sg_result_t predict_load(input sg_item_t it);
    sg_result_t  r;
    int unsigned depth;
    int unsigned n_slots;
    int unsigned room;
    logic [63:0] a;
    r = '0;
    depth = (cfg_depth > SLOTS) ? SLOTS : cfg_depth;
    if (it.req_type) begin
      r.status = STS_ACCEPTED;
      r.addr = tbl_addr[it.rd_idx];
      r.key = tbl_key[it.rd_idx];
      return r;
    end
    if (it.first_desc) begin
      msg_open = 1'b1;
      fill_ptr = 0;
      desc_seen = '0;
      len_sum = '0;
      desc_expected = it.count;
      if (it.count == 0 || depth == 0 || depth % it.count != 0) begin
        return close_msg(STS_BAD_COUNT);
      end
      if (sig_bits(32'(it.count) - 32'd1) + sig_bits(32'(cfg_chunk) - 32'd1) >
          IMM_PAYLOAD_BITS) begin
        return close_msg(STS_IMM_SMALL);
      end
    end else if (!msg_open) begin
      r.status = STS_IGNORED;
      return r;
    end
    if (fill_ptr >= depth) begin
      return close_msg(STS_NOT_MAPPED);
    end
    len_sum = len_sum + it.len;
    if (it.len == 0 || cfg_chunk == 0 || it.len % cfg_chunk != 0) begin
      return close_msg(STS_BAD_LEN);
    end
    n_slots = it.len / cfg_chunk;
    room = depth - fill_ptr;
    if (n_slots > room) begin
      n_slots = room;
    end
    a = it.addr;
    repeat (n_slots) begin
      tbl_addr[fill_ptr] = a;
      tbl_key[fill_ptr] = it.key;
      if (!tbl_written[fill_ptr]) begin
        tbl_written[fill_ptr] = 1'b1;
        written_slots.push_back(fill_ptr);
      end
      fill_ptr++;
      a = a + 64'(cfg_chunk);
    end
    desc_seen = desc_seen + 16'd1;
    if (desc_seen != desc_expected) begin
      r.status = STS_ACCEPTED;
      return r;
    end
    if (fill_ptr != depth) begin
      return close_msg(STS_NOT_MAPPED);
    end
    if (len_sum != 32'(cfg_chunk * depth)) begin
      return close_msg(STS_BAD_TOTAL);
    end
    return close_msg(STS_VALID);
  endfunction

  function automatic sg_item_t mk_desc(input bit first_desc, input logic [15:0] count,
                                       input logic [63:0] addr, input logic [31:0] key,
                                       input logic [31:0] len);
    sg_item_t it;
    it.req_type = 1'b0;
    it.first_desc = first_desc;
    it.count = count;
    it.addr = addr;
    it.key = key;
    it.len = len;
    it.rd_idx = RIDX_W'($urandom);
    return it;
  endfunction

  function automatic sg_item_t mk_read(input int unsigned idx);
    sg_item_t it;
    it = mk_desc($urandom_range(1), 16'($urandom), {$urandom, $urandom}, $urandom, $urandom);
    it.req_type = 1'b1;
    it.rd_idx = RIDX_W'(idx);
    return it;
  endfunction

  function automatic logic [63:0] rand_addr();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one input transfer; the valid stays up so back-to-back items need no gap
  task automatic send_item(input sg_item_t it);
    sg_result_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, it.rd_idx, it.len, it.key, it.addr, it.count};
    s_axis_tuser  <= {it.first_desc, it.req_type};
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_load(it);
    result_q.push_back(want);
    if (want.status != STS_IGNORED) begin
      items_done++;
    end
  endtask

  // registers change only with no result outstanding
  task automatic set_config(input int unsigned depth, input int unsigned chunk);
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_QUEUE_DEPTH;
    cfg_data_i  <= CFG_DAT_W'(depth);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_depth = QDEPTH_W'(depth);
    cfg_index_i <= REG_CHUNK_SIZE;
    cfg_data_i  <= CFG_DAT_W'(chunk);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_chunk = CHUNK_W'(chunk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_read();
    send_item(mk_read(written_slots[$urandom_range(written_slots.size() - 1)]));
  endtask

  // a message with random content, well formed unless a flaw is drawn
  task automatic send_message();
    int unsigned depth;
    int unsigned cnt;
    int unsigned victim;
    int unsigned divs [$];
    int unsigned parts [$];
    msg_flaw_e   flaw;
    logic [63:0] base;
    logic [31:0] len;
    logic [15:0] cnt_field;
    depth = (cfg_depth > SLOTS) ? SLOTS : cfg_depth;
    for (int unsigned i = 1; i <= depth; i++) begin
      if (depth % i == 0) divs.push_back(i);
    end
    cnt = (depth == 0) ? $urandom_range(1, 8) : divs[$urandom_range(divs.size() - 1)];
    for (int unsigned i = 0; i < cnt; i++) parts.push_back(1);
    for (int unsigned i = cnt; i < depth; i++) parts[$urandom_range(cnt - 1)]++;
    flaw = ($urandom_range(99) < 70) ? FLAW_NONE : msg_flaw_e'($urandom_range(1, 7));
    victim = $urandom_range(cnt - 1);
    if (flaw == FLAW_OVERFILL) begin
      parts[0] = depth;
    end
    base = rand_addr();
    for (int unsigned i = 0; i < cnt; i++) begin
      if (flaw == FLAW_CUT && i == victim && victim > 0) break;
      len = 32'(parts[i] * cfg_chunk);
      if (i == victim) begin
        case (flaw)
          FLAW_ZERO_LEN: len = '0;
          FLAW_ODD_LEN:  len = (cfg_chunk > 1) ? len + $urandom_range(1, cfg_chunk - 1)
                                               : $urandom;
          FLAW_LONG:     len = len + 32'(cfg_chunk * $urandom_range(1, 4));
          FLAW_SHORT:    len = len - 32'(cfg_chunk);
          default: ;
        endcase
      end
      cnt_field = (i == 0 && flaw != FLAW_COUNT) ? 16'(cnt) : 16'($urandom);
      send_item(mk_desc(i == 0, cnt_field, base, $urandom, len));
      base = ($urandom_range(3) == 0) ? rand_addr() : base + 64'(len);
      if (written_slots.size() != 0 && $urandom_range(99) < 8) send_read();
    end
  endtask

  task automatic pick_config();
    int unsigned depth;
    int unsigned chunk;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)       depth = 0;
    else if (r < 10) depth = $urandom_range(513, 1023);
    else if (r < 16) depth = 512;
    else if (r < 30) depth = $urandom_range(33, 511);
    else             depth = $urandom_range(1, 32);
    r = $urandom_range(99);
    if (r < 4)       chunk = 0;
    else if (r < 10) chunk = 2097151;
    else if (r < 20) chunk = $urandom_range(1, 2097151);
    else if (r < 30) chunk = 1;
    else if (r < 60) chunk = 1 << $urandom_range(0, 12);
    else             chunk = $urandom_range(1, 4096);
    set_config(depth, chunk);
  endtask

  task automatic test_directed_cases();
    sg_item_t it;
    send_item(mk_desc(1'b0, 16'd1, '1, '1, 32'd65536));
    send_item(mk_desc(1'b1, 16'd0, '0, '0, 32'd65536));
    send_item(mk_desc(1'b1, 16'hFFFF, '1, '1, '1));
    set_config(8, 16);
    send_item(mk_desc(1'b1, 16'd3, '0, '0, 32'd64));
    send_item(mk_desc(1'b1, 16'd2, '1, '1, 32'd64));
    send_item(mk_desc(1'b0, 16'd0, '0, '0, 32'd64));
    send_item(mk_read(0));
    send_item(mk_read(7));
    send_item(mk_desc(1'b1, 16'd1, rand_addr(), $urandom, 32'd0));
    send_item(mk_desc(1'b1, 16'd1, rand_addr(), $urandom, 32'd17));
    // short of a full table
    send_item(mk_desc(1'b1, 16'd2, rand_addr(), $urandom, 32'd32));
    send_item(mk_desc(1'b0, 16'd2, rand_addr(), $urandom, 32'd16));
    // too long: clipped to the table, total off
    send_item(mk_desc(1'b1, 16'd1, rand_addr(), $urandom, 32'd256));
    // table full with a descriptor left
    send_item(mk_desc(1'b1, 16'd2, rand_addr(), $urandom, 32'd128));
    send_item(mk_desc(1'b0, 16'd2, rand_addr(), $urandom, 32'd16));
    // restart while open, with a read in between
    send_item(mk_desc(1'b1, 16'd2, rand_addr(), $urandom, 32'd64));
    send_item(mk_read(3));
    send_item(mk_desc(1'b1, 16'd1, rand_addr(), $urandom, 32'd128));
    set_config(0, 16);
    send_item(mk_desc(1'b1, 16'd1, rand_addr(), $urandom, 32'd16));
    // depth above the slot count saturates
    set_config(1023, 16);
    send_item(mk_desc(1'b1, 16'd1, rand_addr(), $urandom, 32'd8192));
    send_item(mk_read(511));
    set_config(512, 2097151);
    send_item(mk_desc(1'b1, 16'd256, rand_addr(), $urandom, 32'd2097151));
    set_config(4, 0);
    send_item(mk_desc(1'b1, 16'd1, rand_addr(), $urandom, 32'd64));
    set_config(1, 1);
    send_item(mk_desc(1'b1, 16'd1, rand_addr(), $urandom, 32'd1));
    send_item(mk_desc(1'b1, 16'd1, rand_addr(), $urandom, '1));
    it = mk_desc(1'b0, 16'd1, rand_addr(), $urandom, 32'd1);
    send_item(it);
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned tx_idle,
                                     input int unsigned rx_idle);
    int unsigned target;
    int unsigned r;
    src_idle_pct = tx_idle;
    snk_idle_pct = rx_idle;
    target = items_done + n;
    while (items_done < target) begin
      if ($urandom_range(99) < 8) pick_config();
      r = $urandom_range(99);
      if (r < 5) begin
        send_item(mk_desc($urandom_range(1), 16'($urandom), {$urandom, $urandom},
                          $urandom, $urandom));
      end else if (r < 15 && written_slots.size() != 0) begin
        send_read();
      end else begin
        send_message();
      end
    end
  endtask

  // the receiver holds off while items keep coming, so the input stalls
  task automatic test_output_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_config(8, 64);
    rx_hold_req = 1'b1;
    repeat (6) send_message();
  endtask

  // result sink with random and long stalls
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = RX_HOLD;
      rx_hold_req = 1'b0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    sg_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $error("result transfer with nothing expected: status %0d", m_axis_tuser);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tlast !== want.done) begin
          $error("message_done: expected %0d, got %0d", want.done, m_axis_tlast);
          err_cnt++;
        end
        if (m_axis_tdata[63:0] !== want.addr) begin
          $error("entry_addr: expected %h, got %h", want.addr, m_axis_tdata[63:0]);
          err_cnt++;
        end
        if (m_axis_tdata[95:64] !== want.key) begin
          $error("entry_key: expected %h, got %h", want.key, m_axis_tdata[95:64]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_QUEUE_DEPTH;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    err_cnt = 0;
    items_done = 0;
    stall_cycles = 0;
    rx_hold_left = 0;
    rx_hold_req = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    cfg_depth = QDEPTH_RST;
    cfg_chunk = CHUNK_RST;
    fill_ptr = 0;
    desc_seen = '0;
    desc_expected = '0;
    len_sum = '0;
    msg_open = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_traffic(400, 38, 66);
    test_random_traffic(400, 66, 38);
    test_output_backpressure();
    test_random_traffic(400, 0, 0);

    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/sgdbl_pkg.sv
hdl/sgdbl_div.sv
hdl/sg_descriptor_buffer_table_loader.sv
dv/tb_top.sv
